// File: sv/apq_pkg.sv
// Package for the array priority queue: result codes, action codes and sequencer states.
`timescale 1ns / 1ps

package apq_pkg;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    // Action codes of an input item
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_REMOVE = 1'b1;

    // Sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

// File: sv/apq_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`timescale 1ns / 1ps

module apq_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: sv/array_priority_queue.sv
// Top level of the minimum-first priority queue kept as an unsorted array in one RAM.
//
//   channel | signals                                    | direction
//   --------+--------------------------------------------+----------
//   in      | in_valid, in_ready, action, priority_req,  | into block
//           | payload                                    |
//   out     | out_valid, out_ready, status, out_priority,| out of block
//           | out_payload, occupancy                     |
//
// An insert writes the entry at the tail in the idle state, then hands the result on.
// A remove scans all n entries through the single RAM read port to find the minimum at
// index k, then the shift loop moves the n - 1 - k entries behind it down, one entry a
// cycle. One item is in work at a time.
// Reset empties the queue at once (the fill count is cleared; entry contents are not).
// A stalled output holds its result in the output register while the next item is taken.
`timescale 1ns / 1ps

module array_priority_queue
    import apq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int DATA_BITS = 16,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 action,
    input  logic [PRIO_BITS-1:0] priority_req,
    input  logic [DATA_BITS-1:0] payload,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [1:0]           status,
    output logic [PRIO_BITS-1:0] out_priority,
    output logic [DATA_BITS-1:0] out_payload,
    output logic [CNT_W-1:0]     occupancy
);

    localparam int AW    = $clog2(DEPTH);
    localparam int ENT_W = PRIO_BITS + DATA_BITS;
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] ONE     = CNT_W'(1);

    state_t state_reg;
    state_t state_next;

    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     cmp_idx_reg;
    logic [CNT_W-1:0]     wr_ptr_reg;
    logic                 first_reg;
    logic [CNT_W-1:0]     best_idx_reg;
    logic [PRIO_BITS-1:0] best_prio_reg;
    logic [DATA_BITS-1:0] best_data_reg;
    logic [CNT_W-1:0]     best_idx_next;
    logic [PRIO_BITS-1:0] best_prio_next;
    logic [DATA_BITS-1:0] best_data_next;

    status_t              res_status_reg;
    logic [PRIO_BITS-1:0] res_prio_reg;
    logic [DATA_BITS-1:0] res_data_reg;

    logic                 out_valid_reg;
    status_t              out_status_reg;
    logic [PRIO_BITS-1:0] out_prio_reg;
    logic [DATA_BITS-1:0] out_data_reg;
    logic [CNT_W-1:0]     out_occ_reg;

    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [ENT_W-1:0] ram_wdata;
    logic             ram_re;
    logic [AW-1:0]    ram_raddr;
    logic [ENT_W-1:0] ram_rdata;

    logic                 in_fire;
    logic                 done_ready;
    logic                 scan_take;
    logic                 scan_last;
    logic                 shift_needed;
    logic                 more_reads;
    logic [CNT_W-1:0]     after_best;
    logic [PRIO_BITS-1:0] rd_prio;
    logic [DATA_BITS-1:0] rd_data;

    apq_ram #(
        .WIDTH (ENT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Split the read word and track the running minimum (first arrival or strictly smaller)
    assign rd_prio   = ram_rdata[DATA_BITS +: PRIO_BITS];
    assign rd_data   = ram_rdata[DATA_BITS-1:0];
    assign scan_take = first_reg || (rd_prio < best_prio_reg);

    always_comb
    begin
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        best_data_next = best_data_reg;
        if (scan_take)
        begin
            best_idx_next  = cmp_idx_reg;
            best_prio_next = rd_prio;
            best_data_next = rd_data;
        end
    end

    assign in_fire      = in_valid && in_ready;
    assign done_ready   = !out_valid_reg || out_ready;
    assign scan_last    = (cmp_idx_reg == (cnt_reg - ONE));
    assign after_best   = best_idx_next + ONE;
    assign shift_needed = (after_best < cnt_reg);
    assign more_reads   = (rd_ptr_reg < cnt_reg);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if ((action == ACT_REMOVE) && (cnt_reg != '0))
                        state_next = S_SCAN;
                    else
                        state_next = S_DONE;
                end
            end
            S_SCAN:
            begin
                if (scan_last)
                    state_next = shift_needed ? S_SHIFT : S_DONE;
            end
            S_SHIFT:
            begin
                if (!more_reads)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (done_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs: RAM ports and input ready
    always_comb
    begin
        in_ready  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = {priority_req, payload};
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (action == ACT_INSERT) && (cnt_reg < CNT_MAX))
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cnt_reg[AW-1:0];
                end
                if (in_valid && (action == ACT_REMOVE) && (cnt_reg != '0))
                begin
                    ram_re    = 1'b1;
                    ram_raddr = '0;
                end
            end
            S_SCAN:
            begin
                if (more_reads)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rd_ptr_reg[AW-1:0];
                end
                else if (scan_last && shift_needed)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = after_best[AW-1:0];
                end
            end
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = wr_ptr_reg[AW-1:0];
                ram_wdata = ram_rdata;
                if (more_reads)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = rd_ptr_reg[AW-1:0];
                end
            end
            S_DONE:
            begin
                in_ready = 1'b0;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // Control registers: state, fill count, first-compare flag, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            first_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            // count up on an accepted insert, down when a remove finishes
            if (in_fire && (action == ACT_INSERT) && (cnt_reg < CNT_MAX))
                cnt_reg <= cnt_reg + ONE;
            else if ((state_reg == S_SCAN) && scan_last && !shift_needed)
                cnt_reg <= cnt_reg - ONE;
            else if ((state_reg == S_SHIFT) && !more_reads)
                cnt_reg <= cnt_reg - ONE;
            // first compare of a scan takes the entry unconditionally
            if (in_fire)
                first_reg <= 1'b1;
            else if (state_reg == S_SCAN)
                first_reg <= 1'b0;
            // load the output register, drop it once taken
            if ((state_reg == S_DONE) && done_ready)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Scan and shift datapath, result and output registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    rd_ptr_reg   <= ONE;
                    cmp_idx_reg  <= '0;
                    res_prio_reg <= '0;
                    res_data_reg <= '0;
                    if (action == ACT_INSERT)
                        res_status_reg <= (cnt_reg < CNT_MAX) ? ST_OK : ST_FULL;
                    else
                        res_status_reg <= (cnt_reg != '0) ? ST_OK : ST_EMPTY;
                end
            end
            S_SCAN:
            begin
                cmp_idx_reg   <= cmp_idx_reg + ONE;
                best_idx_reg  <= best_idx_next;
                best_prio_reg <= best_prio_next;
                best_data_reg <= best_data_next;
                if (more_reads)
                    rd_ptr_reg <= rd_ptr_reg + ONE;
                if (scan_last)
                begin
                    res_prio_reg <= best_prio_next;
                    res_data_reg <= best_data_next;
                    wr_ptr_reg   <= best_idx_next;
                    rd_ptr_reg   <= after_best + ONE;
                end
            end
            S_SHIFT:
            begin
                wr_ptr_reg <= wr_ptr_reg + ONE;
                if (more_reads)
                    rd_ptr_reg <= rd_ptr_reg + ONE;
            end
            S_DONE:
            begin
                if (done_ready)
                begin
                    out_status_reg <= res_status_reg;
                    out_prio_reg   <= res_prio_reg;
                    out_data_reg   <= res_data_reg;
                    out_occ_reg    <= cnt_reg;
                end
            end
            default:
            begin
                rd_ptr_reg <= rd_ptr_reg;
            end
        endcase
    end

    // Drive the result channel
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign out_priority = out_prio_reg;
    assign out_payload  = out_data_reg;
    assign occupancy    = out_occ_reg;

endmodule

// File: sv/apq_checker.sv
// Port-level checker for the array priority queue, bound to the top level.
`timescale 1ns / 1ps

module apq_checker
    import apq_pkg::*;
#(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 8,
    parameter int DATA_BITS = 16,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input logic                 out_valid,
    input logic                 out_ready,
    input logic [1:0]           status,
    input logic [PRIO_BITS-1:0] out_priority,
    input logic [DATA_BITS-1:0] out_payload,
    input logic [CNT_W-1:0]     occupancy
);

    // A full reject only happens with every slot taken
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_FULL)) |-> (occupancy == CNT_W'(DEPTH)))
        else $error("full status with queue not full");

    // An empty reject only happens with no entry held
    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_EMPTY)) |-> (occupancy == '0))
        else $error("empty status with entries held");

    // Rejected items carry zero result fields
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> ((out_priority == '0) && (out_payload == '0)))
        else $error("rejected item returned data");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(status) && $stable(occupancy)))
        else $error("stalled result changed");

    // One item in work at a time: a transfer closes the input for the next cycle
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken twice in a row");

endmodule

bind array_priority_queue apq_checker #(
    .DEPTH     (DEPTH),
    .PRIO_BITS (PRIO_BITS),
    .DATA_BITS (DATA_BITS)
) u_apq_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .out_priority (out_priority),
    .out_payload  (out_payload),
    .occupancy    (occupancy)
);
